// ===== rtl/core/tms_pkg.sv =====
package tms_pkg;

  localparam int C_W     = 28;
  localparam int SW_W    = 20;
  localparam int QW_W    = 28;
  localparam int METH_W  = 3;
  localparam int AREA_W  = 13;
  localparam int TS_W    = 20;
  localparam int TQ_W    = 28;
  localparam int CFG_W   = 28;
  localparam int IDX_W   = 2;
  localparam int SCORE_W = 48;

  localparam int MAX_TEMPLATE_AREA = 4096;

  // squared difference before clipping fits in 30 bits
  localparam int D_W   = 30;
  // magnitudes of numerators and variances
  localparam int MAG_W = 41;
  // products of two magnitudes
  localparam int PRD_W = 2 * MAG_W;
  // working width for saturation
  localparam int SAT_W = 64;

  localparam logic [SCORE_W-1:0] SCORE_MAX = (SCORE_W'(1) << (SCORE_W - 1)) - SCORE_W'(1);
  localparam logic [SCORE_W-1:0] SCORE_MIN = SCORE_W'(1) << (SCORE_W - 1);

  typedef enum logic [METH_W-1:0] {
    M_SQDIFF        = 3'd0,
    M_SQDIFF_NORMED = 3'd1,
    M_CCORR         = 3'd2,
    M_CCORR_NORMED  = 3'd3,
    M_CCOEFF        = 3'd4,
    M_CCOEFF_NORMED = 3'd5
  } method_t;

  typedef enum logic [IDX_W-1:0] {
    REG_METHOD = 2'd0,
    REG_AREA   = 2'd1,
    REG_TSUM   = 2'd2,
    REG_TSQSUM = 2'd3
  } reg_idx_t;

  // how the final score of an item is formed
  typedef enum logic [1:0] {
    KIND_FIXED,
    KIND_QUOT,
    KIND_NORM,
    KIND_ROOT
  } kind_t;

  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic                 neg;
    logic [SCORE_W-1:0]   fixed;
  } side_t;

  function automatic logic [SCORE_W-1:0] sat_score(input logic neg,
                                                   input logic [SAT_W-1:0] mag);
    logic [SAT_W-1:0] lim;
    logic [SAT_W-1:0] m;
    lim = SAT_W'(1) << (SCORE_W - 1);
    if (neg) begin
      m = (mag > lim) ? lim : mag;
      sat_score = SCORE_W'(~m + SAT_W'(1));
    end else begin
      m = (mag >= lim) ? (lim - SAT_W'(1)) : mag;
      sat_score = m[SCORE_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/tms_front.sv =====
module tms_front #(
  parameter int FB = 16,
  parameter int QB = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic [tms_pkg::C_W-1:0]           c,
  input  logic [tms_pkg::SW_W-1:0]          sw,
  input  logic [tms_pkg::QW_W-1:0]          qw,
  input  logic [tms_pkg::METH_W-1:0]        meth,
  input  logic [tms_pkg::AREA_W-1:0]        area,
  input  logic [tms_pkg::TS_W-1:0]          tsum,
  input  logic [tms_pkg::TQ_W-1:0]          tsqsum,
  output tms_pkg::side_t                    side_o,
  output logic [tms_pkg::PRD_W-1:0]         num_o,
  output logic [tms_pkg::PRD_W-1:0]         den_o
);

  localparam int MW = tms_pkg::MAG_W;
  localparam int PW = tms_pkg::PRD_W;
  localparam int SW = tms_pkg::SAT_W;
  localparam int OW = tms_pkg::SCORE_W;
  localparam int LO = 21;
  localparam int HW = MW - LO;
  localparam int OVF_SH = OW - 1 - FB;
  localparam int DEN_SH = QB - FB - 1;
  localparam logic [OW-1:0] ONE_Q = OW'(1) << FB;
  localparam logic [SW-1:0] INT_LIM = SW'(tms_pkg::SCORE_MAX) >> FB;

  function automatic logic [OW-1:0] shift_int(input logic [tms_pkg::D_W-1:0] v);
    logic [SW-1:0] w;
    w = SW'(v);
    if (w > INT_LIM) shift_int = tms_pkg::SCORE_MAX;
    else shift_int = OW'(w << FB);
  endfunction

  // stage 1: products and raw squared difference
  logic [tms_pkg::AREA_W-1:0] a_cl;
  logic                       v1;
  logic [tms_pkg::METH_W-1:0] m1;
  logic [tms_pkg::AREA_W-1:0] a1;
  logic [tms_pkg::C_W-1:0]    c1;
  logic [tms_pkg::QW_W-1:0]   qw1;
  logic [tms_pkg::TQ_W-1:0]   qt1;
  logic [MW-1:0]              p_ac1, p_sst1, p_aqt1, p_stst1, p_aqw1, p_swsw1;
  logic signed [tms_pkg::D_W:0] dr1;

  always_comb begin
    if (area == '0) a_cl = tms_pkg::AREA_W'(1);
    else if (area > tms_pkg::AREA_W'(tms_pkg::MAX_TEMPLATE_AREA))
      a_cl = tms_pkg::AREA_W'(tms_pkg::MAX_TEMPLATE_AREA);
    else a_cl = area;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1      <= in_valid;
      m1      <= meth;
      a1      <= a_cl;
      c1      <= c;
      qw1     <= qw;
      qt1     <= tsqsum;
      p_ac1   <= MW'(a_cl) * MW'(c);
      p_sst1  <= MW'(sw) * MW'(tsum);
      p_aqt1  <= MW'(a_cl) * MW'(tsqsum);
      p_stst1 <= MW'(tsum) * MW'(tsum);
      p_aqw1  <= MW'(a_cl) * MW'(qw);
      p_swsw1 <= MW'(sw) * MW'(sw);
      dr1     <= $signed({3'b000, qw}) + $signed({3'b000, tsqsum})
                 - $signed({2'b00, c, 1'b0});
    end
  end

  // stage 2: differences, clipping and method decode
  logic signed [MW:0]        n2c, t2c;
  logic                      nneg, tpos;
  logic [MW-1:0]             nmag, wvar;
  logic [tms_pkg::D_W-1:0]   dcl;
  tms_pkg::side_t            s2_next, s2;
  logic                      sqd2_next, sqd2;
  logic [MW-1:0]             mm2_next, x2_next, y2_next, mm2, x2, y2;
  logic [tms_pkg::AREA_W-1:0] a2;

  always_comb begin
    n2c  = $signed({1'b0, p_ac1}) - $signed({1'b0, p_sst1});
    t2c  = $signed({1'b0, p_aqt1}) - $signed({1'b0, p_stst1});
    nneg = n2c[MW];
    nmag = nneg ? MW'(-n2c) : n2c[MW-1:0];
    tpos = !t2c[MW] && (t2c != '0);
    wvar = (p_aqw1 > p_swsw1) ? (p_aqw1 - p_swsw1) : '0;
    dcl  = dr1[tms_pkg::D_W] ? '0 : dr1[tms_pkg::D_W-1:0];

    s2_next.valid = v1;
    s2_next.kind  = tms_pkg::KIND_FIXED;
    s2_next.neg   = 1'b0;
    s2_next.fixed = '0;
    sqd2_next     = 1'b0;
    mm2_next      = '0;
    x2_next       = MW'(qw1);
    y2_next       = MW'(qt1);
    unique case (m1)
      tms_pkg::M_SQDIFF_NORMED: begin
        s2_next.kind = tms_pkg::KIND_NORM;
        sqd2_next    = 1'b1;
        mm2_next     = MW'(dcl);
      end
      tms_pkg::M_CCORR: begin
        s2_next.fixed = shift_int(tms_pkg::D_W'(c1));
      end
      tms_pkg::M_CCORR_NORMED: begin
        s2_next.kind = tms_pkg::KIND_NORM;
        mm2_next     = MW'(c1);
      end
      tms_pkg::M_CCOEFF: begin
        s2_next.kind = tms_pkg::KIND_QUOT;
        s2_next.neg  = nneg;
        mm2_next     = nmag;
      end
      tms_pkg::M_CCOEFF_NORMED: begin
        if (tpos) begin
          s2_next.kind = tms_pkg::KIND_NORM;
          s2_next.neg  = nneg;
          mm2_next     = nmag;
          x2_next      = wvar;
          y2_next      = t2c[MW-1:0];
        end else begin
          // constant template
          s2_next.fixed = ONE_Q;
        end
      end
      default: begin
        s2_next.fixed = shift_int(dcl);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (adv) begin
      s2   <= s2_next;
      sqd2 <= sqd2_next;
      mm2  <= mm2_next;
      x2   <= x2_next;
      y2   <= y2_next;
      a2   <= a1;
    end
  end

  // stage 3: partial products of num^2 and x*y
  tms_pkg::side_t             s3;
  logic                       sqd3;
  logic [MW-1:0]              mm3;
  logic [tms_pkg::AREA_W-1:0] a3;
  logic [2*HW-1:0]            mhh, xhh;
  logic [HW+LO-1:0]           mhl, xhl, xlh;
  logic [2*LO-1:0]            mll, xll;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.valid <= 1'b0;
    end else if (adv) begin
      s3   <= s2;
      sqd3 <= sqd2;
      mm3  <= mm2;
      a3   <= a2;
      mhh  <= (2*HW)'(mm2[MW-1:LO]) * (2*HW)'(mm2[MW-1:LO]);
      mhl  <= (HW+LO)'(mm2[MW-1:LO]) * (HW+LO)'(mm2[LO-1:0]);
      mll  <= (2*LO)'(mm2[LO-1:0]) * (2*LO)'(mm2[LO-1:0]);
      xhh  <= (2*HW)'(x2[MW-1:LO]) * (2*HW)'(y2[MW-1:LO]);
      xhl  <= (HW+LO)'(x2[MW-1:LO]) * (HW+LO)'(y2[LO-1:0]);
      xlh  <= (HW+LO)'(x2[LO-1:0]) * (HW+LO)'(y2[MW-1:LO]);
      xll  <= (2*LO)'(x2[LO-1:0]) * (2*LO)'(y2[LO-1:0]);
    end
  end

  // stage 4: sum partial products
  tms_pkg::side_t             s4;
  logic                       sqd4;
  logic [MW-1:0]              mm4;
  logic [tms_pkg::AREA_W-1:0] a4;
  logic [PW-1:0]              big_m4, big_p4;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.valid <= 1'b0;
    end else if (adv) begin
      s4     <= s3;
      sqd4   <= sqd3;
      mm4    <= mm3;
      a4     <= a3;
      big_m4 <= (PW'(mhh) << (2*LO)) + (PW'(mhl) << (LO+1)) + PW'(mll);
      big_p4 <= (PW'(xhh) << (2*LO)) + ((PW'(xhl) + PW'(xlh)) << LO) + PW'(xll);
    end
  end

  // stage 5: range tests, divider operands
  logic              lt, lt81, ovf;
  logic [PW+6:0]     lhs81, rhs81;
  logic [PW-1:0]     ovf_lim, den_a;
  tms_pkg::side_t    s5_next;
  logic [PW-1:0]     num_next, den_next;

  always_comb begin
    lt      = big_m4 < big_p4;
    lhs81   = (PW+7)'(big_m4) << 6;
    rhs81   = ((PW+7)'(big_p4) << 6) + ((PW+7)'(big_p4) << 4) + (PW+7)'(big_p4);
    lt81    = lhs81 < rhs81;
    ovf_lim = PW'(a4) << OVF_SH;
    den_a   = PW'(a4) << DEN_SH;
    ovf     = PW'(mm4) >= ovf_lim;

    s5_next  = s4;
    num_next = PW'(mm4);
    den_next = den_a;
    case (s4.kind)
      tms_pkg::KIND_QUOT: begin
        if (ovf) begin
          s5_next.kind  = tms_pkg::KIND_FIXED;
          s5_next.fixed = s4.neg ? tms_pkg::SCORE_MIN : tms_pkg::SCORE_MAX;
        end
      end
      tms_pkg::KIND_NORM: begin
        if (lt) begin
          s5_next.kind = tms_pkg::KIND_ROOT;
          num_next     = big_m4;
          den_next     = big_p4;
        end else if (lt81) begin
          s5_next.kind  = tms_pkg::KIND_FIXED;
          s5_next.fixed = tms_pkg::sat_score(s4.neg, SW'(ONE_Q));
        end else begin
          s5_next.kind  = tms_pkg::KIND_FIXED;
          s5_next.fixed = sqd4 ? ONE_Q : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_o.valid <= 1'b0;
    end else if (adv) begin
      side_o <= s5_next;
      num_o  <= num_next;
      den_o  <= den_next;
    end
  end

endmodule

// ===== rtl/core/tms_div.sv =====
module tms_div #(
  parameter int QB = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  tms_pkg::side_t            side_i,
  input  logic [tms_pkg::PRD_W-1:0] num_i,
  input  logic [tms_pkg::PRD_W-1:0] den_i,
  output tms_pkg::side_t            side_o,
  output logic [QB-1:0]             q_o
);

  localparam int PW = tms_pkg::PRD_W;

  tms_pkg::side_t  sd [0:QB-1];
  logic [PW-1:0]   rr [0:QB-1];
  logic [PW-1:0]   dd [0:QB-1];
  logic [QB-1:0]   qq [0:QB-1];

  // one quotient bit per stage; numerator is below the divisor
  for (genvar i = 0; i < QB; i++) begin : g_stage
    tms_pkg::side_t s_in;
    logic [PW-1:0]  r_in, d_in;
    logic [QB-1:0]  q_in;
    logic [PW:0]    r2, diff;
    logic           ge;

    if (i == 0) begin : g_first
      assign s_in = side_i;
      assign r_in = num_i;
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign s_in = sd[i-1];
      assign r_in = rr[i-1];
      assign d_in = dd[i-1];
      assign q_in = qq[i-1];
    end

    assign r2   = {r_in, 1'b0};
    assign diff = r2 - {1'b0, d_in};
    assign ge   = r2 >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i].valid <= 1'b0;
      end else if (adv) begin
        sd[i] <= s_in;
        rr[i] <= ge ? diff[PW-1:0] : r2[PW-1:0];
        dd[i] <= d_in;
        qq[i] <= {q_in[QB-2:0], ge};
      end
    end
  end

  assign side_o = sd[QB-1];
  assign q_o    = qq[QB-1];

endmodule

// ===== rtl/core/tms_sqrt.sv =====
module tms_sqrt #(
  parameter int FB = 16,
  parameter int QB = 48
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  tms_pkg::side_t side_i,
  input  logic [QB-1:0]  q_i,
  output tms_pkg::side_t side_o,
  output logic [QB-1:0]  q_o,
  output logic [FB:0]    root_o
);

  localparam int NS = FB + 1;
  localparam int RB = 2 * FB + 2;

  tms_pkg::side_t sd [0:NS-1];
  logic [QB-1:0]  qq [0:NS-1];
  logic [FB:0]    rt [0:NS-1];

  // one root bit per stage, most significant first
  for (genvar j = 0; j < NS; j++) begin : g_stage
    tms_pkg::side_t s_in;
    logic [QB-1:0]  q_in;
    logic [FB:0]    rt_in, cand;
    logic [RB-1:0]  sq, qv;

    if (j == 0) begin : g_first
      assign s_in  = side_i;
      assign q_in  = q_i;
      assign rt_in = '0;
    end else begin : g_next
      assign s_in  = sd[j-1];
      assign q_in  = qq[j-1];
      assign rt_in = rt[j-1];
    end

    assign qv   = q_in[QB-1 -: RB];
    assign cand = rt_in | ((FB+1)'(1) << (FB - j));
    assign sq   = RB'(cand) * RB'(cand);

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[j].valid <= 1'b0;
      end else if (adv) begin
        sd[j] <= s_in;
        qq[j] <= q_in;
        rt[j] <= (sq <= qv) ? cand : rt_in;
      end
    end
  end

  assign side_o = sd[NS-1];
  assign q_o    = qq[NS-1];
  assign root_o = rt[NS-1];

endmodule

// ===== rtl/core/template_match_score_normalize.sv =====
// Channel  | Handshake             | Beat contents
// ---------+-----------------------+---------------------------------------------
// in       | in_valid / in_ready   | cross_corr, window_sum, window_sqsum
// out      | out_valid / out_ready | score (signed, FRACTION_BITS fraction bits)
// cfg      | cfg_wr                | cfg_idx, cfg_data
//
// One beat per cycle in and out unless the output is stalled. The pipeline is
// five front stages, the divider, one stage per root bit and the output register,
// where QB = max(48, 2*FRACTION_BITS + 2) is the number of stages of the restoring
// divider.
// Synchronous reset clears valid bits and restores register defaults.
// A stalled output register freezes every stage; nothing is dropped or repeated.
module template_match_score_normalize #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tms_pkg::C_W-1:0]            cross_corr,
  input  logic [tms_pkg::SW_W-1:0]           window_sum,
  input  logic [tms_pkg::QW_W-1:0]           window_sqsum,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tms_pkg::SCORE_W-1:0] score,
  input  logic                               cfg_wr,
  input  logic [tms_pkg::IDX_W-1:0]          cfg_idx,
  input  logic [tms_pkg::CFG_W-1:0]          cfg_data
);

  localparam int QB = (2 * FRACTION_BITS + 2 > 48) ? (2 * FRACTION_BITS + 2) : 48;
  localparam int SW = tms_pkg::SAT_W;

  logic [tms_pkg::METH_W-1:0] method;
  logic [tms_pkg::AREA_W-1:0] template_area;
  logic [tms_pkg::TS_W-1:0]   template_sum;
  logic [tms_pkg::TQ_W-1:0]   template_sqsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      method         <= tms_pkg::M_CCORR;
      template_area  <= tms_pkg::AREA_W'(1);
      template_sum   <= '0;
      template_sqsum <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tms_pkg::REG_METHOD: method         <= cfg_data[tms_pkg::METH_W-1:0];
        tms_pkg::REG_AREA:   template_area  <= cfg_data[tms_pkg::AREA_W-1:0];
        tms_pkg::REG_TSUM:   template_sum   <= cfg_data[tms_pkg::TS_W-1:0];
        tms_pkg::REG_TSQSUM: template_sqsum <= cfg_data[tms_pkg::TQ_W-1:0];
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  tms_pkg::side_t             side_f, side_d, side_s;
  logic [tms_pkg::PRD_W-1:0]  num_f, den_f;
  logic [QB-1:0]              q_d, q_s;
  logic [FRACTION_BITS:0]     root_s;

  tms_front #(.FB(FRACTION_BITS), .QB(QB)) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .c        (cross_corr),
    .sw       (window_sum),
    .qw       (window_sqsum),
    .meth     (method),
    .area     (template_area),
    .tsum     (template_sum),
    .tsqsum   (template_sqsum),
    .side_o   (side_f),
    .num_o    (num_f),
    .den_o    (den_f)
  );

  tms_div #(.QB(QB)) u_div (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .side_i (side_f),
    .num_i  (num_f),
    .den_i  (den_f),
    .side_o (side_d),
    .q_o    (q_d)
  );

  tms_sqrt #(.FB(FRACTION_BITS), .QB(QB)) u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .side_i (side_d),
    .q_i    (q_d),
    .side_o (side_s),
    .q_o    (q_s),
    .root_o (root_s)
  );

  // round half up and saturate
  logic [tms_pkg::SCORE_W-1:0] score_next;
  logic [SW-1:0]               q_rnd, r_rnd;

  always_comb begin
    q_rnd = (SW'(q_s) + SW'(1)) >> 1;
    r_rnd = (SW'(root_s) + SW'(1)) >> 1;
    case (side_s.kind)
      tms_pkg::KIND_QUOT: score_next = tms_pkg::sat_score(side_s.neg, q_rnd);
      tms_pkg::KIND_ROOT: score_next = tms_pkg::sat_score(side_s.neg, r_rnd);
      default:            score_next = side_s.fixed;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= side_s.valid;
      score     <= $signed(score_next);
    end
  end

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(side_s.valid))
    else $error("output beat without a pipeline item");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
